/* hw/rtl/mndt_pkg.sv */
package mndt_pkg;

  // Field widths
  localparam int TrackW = 4;
  localparam int StatusW = 8;
  localparam int KeyW = 7;
  localparam int VelW = 7;
  localparam int TickW = 32;

  // Keys per track; one table row per key
  localparam int NumKeys = 128;

  // Status byte decoding
  localparam logic [StatusW-1:0] StatusKindMask = 8'hF0;
  localparam logic [StatusW-1:0] StatusNoteOn = 8'h90;
  localparam logic [StatusW-1:0] StatusNoteOff = 8'h80;

  // Operation carried into the table stage
  typedef enum logic {
    OP_NOTE_ON,
    OP_NOTE_OFF
  } op_e;

  // One table entry: sounding flag and start tick
  typedef struct packed {
    logic             sounding;
    logic [TickW-1:0] start;
  } entry_t;

endpackage

/* hw/rtl/mndt_table.sv */
module mndt_table import mndt_pkg::*; #(
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output entry_t                   rd_data_o,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  entry_t                   wr_data_i,
  output logic                     busy_o
);

  localparam int AddrW = $clog2(DEPTH);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(DEPTH - 1);

  entry_t           mem_q [DEPTH];
  entry_t           rd_data_q;
  logic             clr_busy_q;
  logic [AddrW-1:0] clr_idx_q;

  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  entry_t           mem_wdata;

  // Clearing pass owns the write port until every entry is silent
  always_comb begin
    if (clr_busy_q) begin
      mem_we    = 1'b1;
      mem_waddr = clr_idx_q;
      mem_wdata = '0;
    end else begin
      mem_we    = wr_en_i;
      mem_waddr = wr_addr_i;
      mem_wdata = wr_data_i;
    end
  end

  // Sweep one entry per cycle after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_idx_q  <= '0;
    end else if (clr_busy_q) begin
      clr_idx_q <= clr_idx_q + 1'b1;
      if (clr_idx_q == LastAddr) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // Single write port, single registered read port; read returns old data
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;
  assign busy_o    = clr_busy_q;

endmodule

/* hw/rtl/midi_note_duration_tracker.sv */
// Channel   Handshake                 Payload
// input     in_valid_i / in_ready_o   track_num_i, status_byte_i, key_num_i, velocity_i,
//                                     event_tick_i
// output    out_valid_o / out_ready_i out_track_o, out_key_o, out_start_o, out_duration_o
//
// One event per cycle unless the output stalls or the table clears: a beat is
// read from the note table at acceptance into the table stage, which updates the
// table entry and registers the result in the result register.
// After reset a clearing pass silences all NUM_TRACKS*128 entries, one per
// cycle, and in_ready_o stays low for those cycles.
// A stalled output holds the table stage, which holds the input.
module midi_note_duration_tracker import mndt_pkg::*; #(
  parameter int NUM_TRACKS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [TrackW-1:0]  track_num_i,
  input  logic [StatusW-1:0] status_byte_i,
  input  logic [KeyW-1:0]    key_num_i,
  input  logic [VelW-1:0]    velocity_i,
  input  logic [TickW-1:0]   event_tick_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [TrackW-1:0]  out_track_o,
  output logic [KeyW-1:0]    out_key_o,
  output logic [TickW-1:0]   out_start_o,
  output logic [TickW-1:0]   out_duration_o
);

  localparam int Depth = NUM_TRACKS * NumKeys;
  localparam int AddrW = $clog2(Depth);
  localparam logic [8:0] NumTracksW = 9'(NUM_TRACKS);

  logic               in_fire;
  logic               tbl_busy;
  logic [AddrW-1:0]   in_addr;
  logic [StatusW-1:0] in_kind;
  logic               in_is_on;
  logic               in_is_off;
  logic               in_relevant;
  op_e                in_op;

  logic               s1_valid_q;
  op_e                s1_op_q;
  logic [AddrW-1:0]   s1_addr_q;
  logic [TrackW-1:0]  s1_track_q;
  logic [KeyW-1:0]    s1_key_q;
  logic [TickW-1:0]   s1_tick_q;
  logic               s1_fire;

  entry_t             rd_data;
  entry_t             cur;
  logic               hit;
  logic               wr_en;
  entry_t             wr_data;

  logic               byp_valid_q;
  logic [AddrW-1:0]   byp_addr_q;
  entry_t             byp_data_q;

  logic               out_valid_q;
  logic [TrackW-1:0]  out_track_q;
  logic [KeyW-1:0]    out_key_q;
  logic [TickW-1:0]   out_start_q;
  logic [TickW-1:0]   out_duration_q;

  // Decode the incoming beat
  assign in_kind     = status_byte_i & StatusKindMask;
  assign in_is_on    = (in_kind == StatusNoteOn);
  assign in_is_off   = (in_kind == StatusNoteOff);
  assign in_relevant = (9'(track_num_i) < NumTracksW) && (in_is_on || in_is_off);
  assign in_op       = (in_is_on && (velocity_i != '0)) ? OP_NOTE_ON : OP_NOTE_OFF;
  assign in_addr     = AddrW'({track_num_i, key_num_i});

  // Advance when the clearing pass is done and the table stage is empty or moves on
  assign s1_fire    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !tbl_busy && (!s1_valid_q || s1_fire);
  assign in_fire    = in_valid_i && in_ready_o;

  mndt_table #(
    .DEPTH(Depth)
  ) u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_fire),
    .rd_addr_i (in_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (s1_addr_q),
    .wr_data_i (wr_data),
    .busy_o    (tbl_busy)
  );

  // Table stage: ignored events drop here
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= in_relevant;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_op_q    <= in_op;
      s1_addr_q  <= in_addr;
      s1_track_q <= track_num_i;
      s1_key_q   <= key_num_i;
      s1_tick_q  <= event_tick_i;
    end
  end

  // Forward the last write over the stale read of the same entry
  assign cur = (byp_valid_q && (byp_addr_q == s1_addr_q)) ? byp_data_q : rd_data;
  assign hit = cur.sounding;

  // Note-on always writes the new start; note-off silences a sounding key
  always_comb begin
    wr_en = s1_fire && ((s1_op_q == OP_NOTE_ON) || hit);
    if (s1_op_q == OP_NOTE_ON) begin
      wr_data.sounding = 1'b1;
      wr_data.start    = s1_tick_q;
    end else begin
      wr_data.sounding = 1'b0;
      wr_data.start    = cur.start;
    end
  end

  // Hold the last write for the read that overlapped it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_valid_q <= 1'b0;
    end else if (wr_en) begin
      byp_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      byp_addr_q <= s1_addr_q;
      byp_data_q <= wr_data;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire && hit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && hit) begin
      out_track_q    <= s1_track_q;
      out_key_q      <= s1_key_q;
      out_start_q    <= cur.start;
      out_duration_q <= s1_tick_q - cur.start;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_track_o    = out_track_q;
  assign out_key_o      = out_key_q;
  assign out_start_o    = out_start_q;
  assign out_duration_o = out_duration_q;

  // No beat enters while the clearing pass runs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tbl_busy |-> !in_ready_o)
    else $error("input accepted during table clear");

  // A silent key closes nothing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && !hit |=> !out_valid_q)
    else $error("result produced for a silent key");

  // A closed note shows its duration from the start tick
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && hit |=> out_valid_q && (out_duration_q == $past(s1_tick_q) - out_start_q))
    else $error("closed note result mismatch");

  // A note-on leaves its key sounding in the forwarding register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && (s1_op_q == OP_NOTE_ON) |=> byp_valid_q && byp_data_q.sounding
      && (byp_addr_q == $past(s1_addr_q)))
    else $error("note-on did not mark key sounding");

endmodule
